### src/ac_current_rms_meter_core_defines.svh
// assertion macros for the rms meter core
`ifndef AC_CURRENT_RMS_METER_CORE_DEFINES_SVH
`define AC_CURRENT_RMS_METER_CORE_DEFINES_SVH

// same-cycle implication
`define ACRMS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ACRMS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/acrms_pkg.sv
package acrms_pkg;

   // shift-add multiplier
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = 64;

   // restoring divider
   localparam int DIV_N_W   = 64;
   localparam int DIV_D_W   = 16;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // bit-pair square root
   localparam int SQ_RAD_W  = 64;
   localparam int SQ_ROOT_W = SQ_RAD_W / 2;
   localparam int SQ_REM_W  = SQ_ROOT_W + 2;
   localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W);

endpackage

### src/acrms_serial_mul.sv
module acrms_serial_mul
   import acrms_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] mcand,
   input  logic [MUL_B_W-1:0] mplier,
   output logic               done,
   output logic [MUL_P_W-1:0] product
);

   logic               run_ff;
   logic [MUL_P_W-1:0] acc_ff;
   logic [MUL_P_W-1:0] shift_ff;
   logic [MUL_B_W-1:0] bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff   <= 1'b1;
         acc_ff   <= '0;
         shift_ff <= MUL_P_W'(mcand);
         bits_ff  <= mplier;
      end else if (run_ff) begin
         if (bits_ff == '0) begin
            run_ff <= 1'b0;
         end else begin
            if (bits_ff[0]) begin
               acc_ff <= acc_ff + shift_ff;
            end
            shift_ff <= shift_ff << 1;
            bits_ff  <= bits_ff >> 1;
         end
      end
   end

   assign done    = run_ff && (bits_ff == '0);
   assign product = acc_ff;

endmodule

### src/acrms_serial_div.sv
module acrms_serial_div
   import acrms_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient
);

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_N_W - 1);

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   div_ff;
   logic [DIV_N_W-1:0]   quo_ff;

   logic [DIV_D_W:0]     trial;
   logic                 fits;
   logic [DIV_D_W-1:0]   rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_N_W-1]};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? DIV_D_W'(trial - {1'b0, div_ff}) : trial[DIV_D_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            div_ff <= divisor;
            quo_ff <= dividend;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_N_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### src/acrms_serial_sqrt.sv
module acrms_serial_sqrt
   import acrms_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_RAD_W-1:0]  radicand,
   output logic                 done,
   output logic [SQ_ROOT_W-1:0] root
);

   localparam logic [SQ_CNT_W-1:0] CNT_LAST = SQ_CNT_W'(SQ_ROOT_W - 1);

   logic                 run_ff;
   logic                 done_ff;
   logic [SQ_CNT_W-1:0]  cnt_ff;
   logic [SQ_RAD_W-1:0]  rad_ff;
   logic [SQ_REM_W-1:0]  rem_ff;
   logic [SQ_ROOT_W-1:0] root_ff;

   logic [SQ_REM_W+1:0]  rem_sh;
   logic [SQ_REM_W+1:0]  trial;
   logic                 fits;
   logic [SQ_REM_W-1:0]  rem_in;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[SQ_RAD_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      fits   = rem_sh >= trial;
      rem_in = fits ? SQ_REM_W'(rem_sh - trial) : rem_sh[SQ_REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            root_ff <= {root_ff[SQ_ROOT_W-2:0], fits};
            rad_ff  <= rad_ff << 2;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### src/ac_current_rms_meter_core.sv
// input stall: an ordinary sample holds off the input for two passes of the shift-add
//   multiplier, at one multiplier bit per cycle
// the closing sample adds two 64-step divider passes, a 32-step root and three more
//   multiplies; a start sample is taken without leaving idle
// throughput: one sample at a time; a finished result waits in the output register
// reset: synchronous, active high; registers to defaults, waits for a start sample
module ac_current_rms_meter_core
   import acrms_pkg::*;
#(
   parameter int ADC_WIDTH = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ADC_WIDTH-1:0] req_sample,
   input  logic                 req_start_req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_current_rms,
   output logic [15:0]          rsp_apparent_power,
   output logic                 rsp_saturated,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data
);

   localparam int Y_W       = 24;
   localparam int MAG_W     = 23;
   localparam int SUM_W     = 48;
   localparam int CNT_W     = 16;
   localparam int DIFF_W    = ADC_WIDTH + 1;
   localparam int T_W       = ((Y_W > ADC_WIDTH + 9) ? Y_W : ADC_WIDTH + 9) + 1;
   localparam int AMP_SHIFT = 8 + ADC_WIDTH;

   localparam logic [MUL_B_W-1:0] COEF_Q16    = 16'd65274;
   localparam logic [MUL_P_W-1:0] ROUND_HALF  = 64'd32768;
   localparam logic [47:0]        Y_LIMIT     = 48'd8388352;
   localparam logic [DIV_D_W-1:0] AMP_DIVISOR = 16'd1000;

   typedef enum logic [1:0] {
      CSR_SAMPLE_COUNT,
      CSR_CALIBRATION,
      CSR_SUPPLY_MV,
      CSR_LINE_VOLTAGE
   } csr_index_type;

   typedef enum logic [3:0] {
      IDLE,
      FILT_ABS,
      FILT_MUL,
      FILT_SAT,
      SQ_GO,
      SQ_MUL,
      COUNT,
      MEAN_DIV,
      ROOT,
      CAL_MUL,
      SUP_MUL,
      AMP_DIV,
      PWR_MUL,
      DELIVER
   } state_type;

   state_type              state_ff;
   logic                   primed_ff;
   logic [ADC_WIDTH-1:0]   prev_ff;
   logic signed [T_W-1:0]  t_ff;
   logic signed [Y_W-1:0]  y_ff;
   logic [MAG_W-1:0]       mag_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   clip_ff;
   logic [MUL_A_W-1:0]     cur_ff;
   logic [15:0]            pw_ff;

   logic [15:0]            sample_count_ff;
   logic [15:0]            calibration_ff;
   logic [15:0]            supply_mv_ff;
   logic [7:0]             line_voltage_ff;

   logic                   rsp_valid_ff;
   logic [15:0]            rsp_current_rms_ff;
   logic [15:0]            rsp_apparent_power_ff;
   logic                   rsp_saturated_ff;

   logic                   mul_go_ff;
   logic [MUL_A_W-1:0]     mul_a_ff;
   logic [MUL_B_W-1:0]     mul_b_ff;
   logic                   div_go_ff;
   logic [DIV_N_W-1:0]     div_n_ff;
   logic [DIV_D_W-1:0]     div_d_ff;
   logic                   sq_go_ff;
   logic [SQ_RAD_W-1:0]    sq_rad_ff;

   logic                   mul_done;
   logic [MUL_P_W-1:0]     mul_product;
   logic                   div_done;
   logic [DIV_N_W-1:0]     div_quotient;
   logic                   sq_done;
   logic [SQ_ROOT_W-1:0]   sq_root;

   logic                   req_accept;
   logic                   rsp_free;
   logic signed [DIFF_W-1:0] diff;
   logic signed [T_W-1:0]  t_in;
   logic [T_W-1:0]         t_mag;
   logic [MUL_P_W-1:0]     rnd;
   logic [47:0]            mag_full;
   logic                   mag_big;
   logic [MAG_W-1:0]       mag_in;
   logic signed [Y_W-1:0]  mag_s;
   logic signed [Y_W-1:0]  y_in;
   logic [MAG_W:0]         w_sum;
   logic [MUL_B_W-1:0]     w;
   logic [SUM_W:0]         sum_wide;
   logic [15:0]            n_eff;
   logic [MUL_P_W-1:0]     q_shift;
   logic                   pw_big;
   logic                   cur_big;

   acrms_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_go_ff),
      .mcand   (mul_a_ff),
      .mplier  (mul_b_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   acrms_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   acrms_serial_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_go_ff),
      .radicand (sq_rad_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_comb begin
      req_accept = req_valid && !req_stall;
      rsp_free   = !rsp_valid_ff || !rsp_stall;
      diff       = $signed({1'b0, req_sample}) - $signed({1'b0, prev_ff});
      t_in       = T_W'(y_ff) + (T_W'(diff) <<< 8);
      t_mag      = t_ff[T_W-1] ? T_W'(-t_ff) : T_W'(t_ff);
      rnd        = mul_product + ROUND_HALF;
      mag_full   = rnd[63:16];
      mag_big    = mag_full > Y_LIMIT;
      mag_in     = mag_big ? Y_LIMIT[MAG_W-1:0] : mag_full[MAG_W-1:0];
      mag_s      = $signed({1'b0, mag_ff});
      y_in       = t_ff[T_W-1] ? -mag_s : mag_s;
      w_sum      = {1'b0, mag_ff} + (MAG_W + 1)'(128);
      w          = w_sum[MAG_W:8];
      sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(mul_product[31:0]);
      n_eff      = (sample_count_ff == '0) ? 16'd1 : sample_count_ff;
      q_shift    = mul_product >> AMP_SHIFT;
      pw_big     = |mul_product[MUL_P_W-1:24];
      cur_big    = |cur_ff[MUL_A_W-1:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= 16'd1480;
         calibration_ff  <= 16'd28442;
         supply_mv_ff    <= 16'd5000;
         line_voltage_ff <= 8'd127;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_data;
            CSR_CALIBRATION:  calibration_ff  <= csr_data;
            CSR_SUPPLY_MV:    supply_mv_ff    <= csr_data;
            CSR_LINE_VOLTAGE: line_voltage_ff <= csr_data[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         primed_ff    <= 1'b0;
         prev_ff      <= '0;
         y_ff         <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         sq_go_ff     <= 1'b0;
      end else begin
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         sq_go_ff  <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_accept) begin
                  if (req_start_req) begin
                     prev_ff   <= req_sample;
                     y_ff      <= '0;
                     sum_ff    <= '0;
                     cnt_ff    <= '0;
                     clip_ff   <= 1'b0;
                     primed_ff <= 1'b1;
                  end else if (primed_ff) begin
                     prev_ff  <= req_sample;
                     t_ff     <= t_in;
                     state_ff <= FILT_ABS;
                  end
               end
            end
            FILT_ABS: begin
               mul_a_ff  <= MUL_A_W'(t_mag);
               mul_b_ff  <= COEF_Q16;
               mul_go_ff <= 1'b1;
               state_ff  <= FILT_MUL;
            end
            FILT_MUL: begin
               if (mul_done) begin
                  state_ff <= FILT_SAT;
               end
            end
            FILT_SAT: begin
               mag_ff <= mag_in;
               if (mag_big) begin
                  clip_ff <= 1'b1;
               end
               state_ff <= SQ_GO;
            end
            SQ_GO: begin
               y_ff      <= y_in;
               mul_a_ff  <= MUL_A_W'(w);
               mul_b_ff  <= w;
               mul_go_ff <= 1'b1;
               state_ff  <= SQ_MUL;
            end
            SQ_MUL: begin
               if (mul_done) begin
                  if (sum_wide[SUM_W]) begin
                     sum_ff  <= '1;
                     clip_ff <= 1'b1;
                  end else begin
                     sum_ff <= sum_wide[SUM_W-1:0];
                  end
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= COUNT;
               end
            end
            COUNT: begin
               if (cnt_ff >= n_eff) begin
                  div_n_ff  <= DIV_N_W'(sum_ff);
                  div_d_ff  <= n_eff;
                  div_go_ff <= 1'b1;
                  state_ff  <= MEAN_DIV;
               end else begin
                  state_ff <= IDLE;
               end
            end
            MEAN_DIV: begin
               if (div_done) begin
                  sq_rad_ff <= {div_quotient[SUM_W-1:0], 16'd0};
                  sq_go_ff  <= 1'b1;
                  state_ff  <= ROOT;
               end
            end
            ROOT: begin
               if (sq_done) begin
                  mul_a_ff  <= MUL_A_W'(sq_root);
                  mul_b_ff  <= calibration_ff;
                  mul_go_ff <= 1'b1;
                  state_ff  <= CAL_MUL;
               end
            end
            CAL_MUL: begin
               if (mul_done) begin
                  mul_a_ff  <= mul_product[MUL_A_W-1:0];
                  mul_b_ff  <= supply_mv_ff;
                  mul_go_ff <= 1'b1;
                  state_ff  <= SUP_MUL;
               end
            end
            SUP_MUL: begin
               if (mul_done) begin
                  div_n_ff  <= q_shift;
                  div_d_ff  <= AMP_DIVISOR;
                  div_go_ff <= 1'b1;
                  state_ff  <= AMP_DIV;
               end
            end
            AMP_DIV: begin
               if (div_done) begin
                  cur_ff    <= div_quotient[MUL_A_W-1:0];
                  mul_a_ff  <= div_quotient[MUL_A_W-1:0];
                  mul_b_ff  <= MUL_B_W'(line_voltage_ff);
                  mul_go_ff <= 1'b1;
                  state_ff  <= PWR_MUL;
               end
            end
            PWR_MUL: begin
               if (mul_done) begin
                  pw_ff    <= pw_big ? 16'hFFFF : mul_product[23:8];
                  clip_ff  <= clip_ff | pw_big | cur_big;
                  state_ff <= DELIVER;
               end
            end
            DELIVER: begin
               if (rsp_free) begin
                  rsp_current_rms_ff    <= cur_big ? 16'hFFFF : cur_ff[15:0];
                  rsp_apparent_power_ff <= pw_ff;
                  rsp_saturated_ff      <= clip_ff;
                  rsp_valid_ff          <= 1'b1;
                  y_ff                  <= '0;
                  sum_ff                <= '0;
                  cnt_ff                <= '0;
                  clip_ff               <= 1'b0;
                  primed_ff             <= 1'b0;
                  state_ff              <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_rms    = rsp_current_rms_ff;
   assign rsp_apparent_power = rsp_apparent_power_ff;
   assign rsp_saturated      = rsp_saturated_ff;

endmodule

### src/acrms_checker.sv
`include "ac_current_rms_meter_core_defines.svh"

module acrms_checker #(
   parameter int ADC_WIDTH = 12
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [ADC_WIDTH-1:0] req_sample,
   input logic                 req_start_req,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [15:0]          rsp_current_rms,
   input logic [15:0]          rsp_apparent_power,
   input logic                 rsp_saturated,
   input logic                 csr_write,
   input logic [1:0]           csr_index,
   input logic [15:0]          csr_data
);

   // a stalled result beat stays put
   `ACRMS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped")
   `ACRMS_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_current_rms) && $stable(rsp_apparent_power) && $stable(rsp_saturated), "rsp payload moved")

   // a start beat never holds off the next beat
   `ACRMS_ASSERT_NXT(a_start_ready, clock, reset, req_valid && !req_stall && req_start_req, !req_stall, "stall after start beat")

   // a result only follows a busy spell
   `ACRMS_ASSERT_IMP(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result without work")

endmodule

bind ac_current_rms_meter_core acrms_checker #(.ADC_WIDTH(ADC_WIDTH)) u_acrms_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int SAMPLE_BITS = 12;
   localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
   localparam longint unsigned RUN_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 320;
   localparam int HOLD_CYCLES = 800;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS = 75;
   localparam longint unsigned COEF_Q16 = 65274;
   localparam longint unsigned FILT_MAX = 32767 * 256;
   localparam longint unsigned SUM_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint unsigned CURRENT_DEN = 64'd256000 << SAMPLE_BITS;
   localparam longint unsigned FIELD_MAX = 65535;

   typedef enum logic [1:0] {
      CSR_SAMPLE_COUNT,
      CSR_CALIBRATION,
      CSR_SUPPLY_MV,
      CSR_LINE_VOLTAGE
   } csr_reg_e;

   typedef enum int {
      WAVE_UNIFORM,
      WAVE_SQUARE,
      WAVE_DRIFT
   } wave_e;

   typedef struct packed {
      logic [15:0] current_rms;
      logic [15:0] apparent_power;
      logic        saturated;
   } reading_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   req_start_req = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [15:0]            rsp_current_rms;
   logic [15:0]            rsp_apparent_power;
   logic                   rsp_saturated;
   logic                   csr_write = 1'b0;
   logic [1:0]             csr_index = '0;
   logic [15:0]            csr_data = '0;

   // predictor copy of registers and measurement state
   logic [15:0]            cfg_count;
   logic [15:0]            cfg_cal;
   logic [15:0]            cfg_mv;
   logic [7:0]             cfg_lv;
   logic [SAMPLE_BITS-1:0] last_sample;
   longint                 filt_q8;
   longint unsigned        energy_sum;
   logic [15:0]            taken;
   bit                     armed;
   bit                     clipped;
   reading_t               pending_readings[$];

   longint unsigned        cycle_count = 0;
   int                     mismatch_count = 0;
   int                     readings_checked = 0;
   int                     saturated_seen = 0;
   int                     beats_sent = 0;
   int                     settings_used = 0;
   int                     meas_len = 1;
   int                     long_hold = 0;
   int                     stall_left = 0;
   bit                     calm = 1'b0;

   ac_current_rms_meter_core #(
      .ADC_WIDTH(SAMPLE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_start_req(req_start_req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_current_rms(rsp_current_rms),
      .rsp_apparent_power(rsp_apparent_power),
      .rsp_saturated(rsp_saturated),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [15:0] pick_reg(input int top);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 20) return top[15:0];
      return $urandom_range(0, top);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] next_sample(input wave_e wave,
                                                         input logic [SAMPLE_BITS-1:0] prev);
      int v;
      case (wave)
         WAVE_SQUARE: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
         WAVE_DRIFT: begin
            v = int'(prev) + int'($urandom_range(0, 160)) - 80;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
         end
         default: v = $urandom_range(0, SAMPLE_MAX);
      endcase
      return v[SAMPLE_BITS-1:0];
   endfunction

   task automatic meter_clear();
      filt_q8 = 0;
      energy_sum = 0;
      taken = '0;
      clipped = 1'b0;
   endtask

   task automatic meter_reset();
      cfg_count = 16'd1480;
      cfg_cal = 16'd28442;
      cfg_mv = 16'd5000;
      cfg_lv = 8'd127;
      last_sample = '0;
      armed = 1'b0;
      meter_clear();
   endtask

   task automatic apply_config(input logic [1:0] idx, input logic [15:0] value);
      case (idx)
         CSR_SAMPLE_COUNT: cfg_count = value;
         CSR_CALIBRATION:  cfg_cal = value;
         CSR_SUPPLY_MV:    cfg_mv = value;
         CSR_LINE_VOLTAGE: cfg_lv = value[7:0];
         default: ;
      endcase
   endtask

   task automatic predict_reading(input logic [SAMPLE_BITS-1:0] x, input logic start);
      longint          t;
      longint unsigned mag;
      longint unsigned w;
      longint unsigned n;
      longint unsigned root;
      longint unsigned cur;
      longint unsigned pw;
      reading_t        r;
      if (start) begin
         last_sample = x;
         meter_clear();
         armed = 1'b1;
         return;
      end
      if (!armed) return;
      t = filt_q8 + 256 * (longint'(x) - longint'(last_sample));
      last_sample = x;
      mag = (t < 0) ? -t : t;
      mag = (mag * COEF_Q16 + 64'd32768) >> 16;
      if (mag > FILT_MAX) begin
         mag = FILT_MAX;
         clipped = 1'b1;
      end
      filt_q8 = (t < 0) ? -longint'(mag) : longint'(mag);
      w = (mag + 64'd128) >> 8;
      if (energy_sum + w * w > SUM_MAX) begin
         energy_sum = SUM_MAX;
         clipped = 1'b1;
      end else begin
         energy_sum = energy_sum + w * w;
      end
      taken = taken + 16'd1;
      n = (cfg_count == 0) ? 1 : cfg_count;
      if (taken < n) return;
      root = int_sqrt((energy_sum / n) << 16);
      cur = root * cfg_cal * cfg_mv / CURRENT_DEN;
      pw = (cur * cfg_lv) >> 8;
      if (pw > FIELD_MAX) begin
         pw = FIELD_MAX;
         clipped = 1'b1;
      end
      if (cur > FIELD_MAX) begin
         cur = FIELD_MAX;
         clipped = 1'b1;
      end
      r.current_rms = cur[15:0];
      r.apparent_power = pw[15:0];
      r.saturated = clipped;
      pending_readings.push_back(r);
      armed = 1'b0;
      meter_clear();
   endtask

   task automatic check_reading();
      reading_t want;
      readings_checked++;
      if (rsp_saturated) saturated_seen++;
      if (pending_readings.size() == 0) begin
         $error("reading with none expected: current_rms %0d apparent_power %0d",
                rsp_current_rms, rsp_apparent_power);
         mismatch_count++;
         return;
      end
      want = pending_readings.pop_front();
      if (rsp_current_rms !== want.current_rms) begin
         $error("current_rms: expected %0d, got %0d", want.current_rms, rsp_current_rms);
         mismatch_count++;
      end
      if (rsp_apparent_power !== want.apparent_power) begin
         $error("apparent_power: expected %0d, got %0d",
                want.apparent_power, rsp_apparent_power);
         mismatch_count++;
      end
      if (rsp_saturated !== want.saturated) begin
         $error("saturated: expected %0d, got %0d", want.saturated, rsp_saturated);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings outstanding",
                  cycle_count, pending_readings.size());
         $display("Simulation FAILED");
         $finish;
      end
      if (reset) begin
         meter_reset();
      end else begin
         if (csr_write) apply_config(csr_index, csr_data);
         if (rsp_valid && !rsp_stall) check_reading();
         if (req_valid && !req_stall) predict_reading(req_sample, req_start_req);
      end
   end

   // result side back-pressure, with an optional long hold
   always @(posedge clock) begin
      if (long_hold > 0) begin
         stall_left = long_hold;
         long_hold = 0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (calm || $urandom_range(0, 99) < 70) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= 1'b1;
      end
   end

   task automatic send_beat(input logic [SAMPLE_BITS-1:0] s, input logic start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_start_req <= start;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic drain_readings();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_e idx, input logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_phase(input logic [15:0] count, input logic [15:0] cal,
                            input logic [15:0] mv, input logic [7:0] lv);
      drain_readings();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(CSR_SAMPLE_COUNT, count);
      write_reg(CSR_CALIBRATION, cal);
      write_reg(CSR_SUPPLY_MV, mv);
      write_reg(CSR_LINE_VOLTAGE, {8'd0, lv});
      meas_len = (count == 0) ? 1 : count;
      settings_used++;
   endtask

   task automatic run_measurement(inout int beats);
      wave_e                  wave;
      logic [SAMPLE_BITS-1:0] x;
      int                     cut;
      wave = wave_e'($urandom_range(0, 2));
      x = $urandom_range(0, SAMPLE_MAX);
      send_beat(x, 1'b1);
      beats++;
      // abandon part way and prime again
      if ($urandom_range(0, 99) < 10) begin
         cut = $urandom_range(0, meas_len - 1);
         repeat (cut) begin
            x = next_sample(wave, x);
            send_beat(x, 1'b0);
            beats++;
         end
         x = next_sample(wave, x);
         send_beat(x, 1'b1);
         beats++;
      end
      repeat (meas_len) begin
         x = next_sample(wave, x);
         send_beat(x, 1'b0);
         beats++;
      end
   endtask

   task automatic test_unprimed_samples();
      send_beat(12'd0, 1'b0);
      send_beat(12'd4095, 1'b0);
      send_beat(12'd1234, 1'b0);
   endtask

   task automatic test_count_and_scale_extremes();
      set_phase(16'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_beat(12'd0, 1'b1);
      send_beat(12'd4095, 1'b0);
      send_beat(12'd4095, 1'b1);
      send_beat(12'd0, 1'b0);
      send_beat(12'd2048, 1'b1);
      send_beat(12'd2048, 1'b0);
   endtask

   task automatic test_zero_scale();
      set_phase(16'd1, 16'd0, 16'd0, 8'd0);
      send_beat(12'd0, 1'b1);
      send_beat(12'd4095, 1'b0);
   endtask

   task automatic test_restart_mid_measurement();
      set_phase(16'd3, 16'd28442, 16'd5000, 8'd127);
      send_beat(12'd100, 1'b1);
      send_beat(12'd3000, 1'b0);
      send_beat(12'd500, 1'b0);
      send_beat(12'd3900, 1'b1);
      send_beat(12'd10, 1'b0);
      send_beat(12'd4000, 1'b0);
      send_beat(12'd2047, 1'b0);
      // back to waiting for a start
      send_beat(12'd777, 1'b0);
   endtask

   task automatic test_longest_count();
      set_phase(16'hFFFF, 16'd40000, 16'd3300, 8'd220);
      send_beat(12'd2048, 1'b1);
      send_beat(12'd4095, 1'b0);
      send_beat(12'd0, 1'b0);
      send_beat(12'd4095, 1'b0);
      send_beat(12'd0, 1'b0);
   endtask

   task automatic test_random_settings();
      int beats;
      int count;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         count = (ph == RANDOM_PHASES - 1) ? $urandom_range(30, 60) : $urandom_range(0, 10);
         set_phase(count[15:0], pick_reg(65535), pick_reg(65535), pick_reg(255));
         calm = (ph == 2);
         beats = 0;
         while (beats < PHASE_BEATS) begin
            run_measurement(beats);
            // stray beats while waiting for a start
            if ($urandom_range(0, 99) < 12) begin
               repeat ($urandom_range(1, 3)) send_beat($urandom_range(0, SAMPLE_MAX), 1'b0);
            end
         end
         calm = 1'b0;
      end
   endtask

   task automatic test_output_backpressure();
      int beats;
      set_phase(16'd1, 16'd28442, 16'd5000, 8'd127);
      calm = 1'b1;
      long_hold = HOLD_CYCLES;
      beats = 0;
      repeat (12) run_measurement(beats);
      calm = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_unprimed_samples();
      test_count_and_scale_extremes();
      test_zero_scale();
      test_restart_mid_measurement();
      test_longest_count();
      test_random_settings();
      test_output_backpressure();
      drain_readings();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d sample beats over %0d register settings, %0d readings checked",
               beats_sent, settings_used, readings_checked);
      $display("%0d readings flagged as clipped, %0d mismatches",
               saturated_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/acrms_pkg.sv
src/acrms_serial_mul.sv
src/acrms_serial_div.sv
src/acrms_serial_sqrt.sv
src/ac_current_rms_meter_core.sv
src/acrms_checker.sv
verif/tb_top.sv
